// ===== sv/lskc_pkg.sv =====
// ============================================================================
// lskc_pkg
// Shared types and constants for the shape-keyed slot cache.
// ============================================================================
package lskc_pkg;

  localparam int ENTRIES_DEF     = 8;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int KEY_W           = 64;
  localparam int STAMP_W         = 32;
  localparam int HANDLE_PORT_W   = 32;
  localparam int OUT_IDX_W       = 3;

  localparam logic CMD_GET   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_DECIDE,
    ST_MV_RD,
    ST_MV_WR,
    ST_CLR_RD,
    ST_CLR_EMIT
  } state_t;

endpackage

// ===== sv/lru_shape_keyed_slot_cache_top.sv =====
// ============================================================================
// lru_shape_keyed_slot_cache_top
// Fully associative LRU cache of shape keys with timestamp replacement.
// ============================================================================
// A get reads the live entries in index order and registers its result; a hit
// ends the scan at that entry. A new beat is accepted once the block is idle,
// even while that result waits on a stalled output.
// A failed allocation when full moves the last entry into the released slot.
// A clear gives one result beat per live entry, then empties the table.
// Reset clears control state, the entry count and the use clock, not the memory.
module lru_shape_keyed_slot_cache_top #(
  parameter int ENTRIES     = lskc_pkg::ENTRIES_DEF,
  parameter int HANDLE_BITS = lskc_pkg::HANDLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [15:0]                        in_key_m,
  input  logic [15:0]                        in_key_k,
  input  logic [15:0]                        in_key_n,
  input  logic [15:0]                        in_key_group,
  input  logic                               in_alloc_ok,
  input  logic [lskc_pkg::HANDLE_PORT_W-1:0] in_alloc_handle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic                               out_granted,
  output logic [lskc_pkg::HANDLE_PORT_W-1:0] out_handle_out,
  output logic [lskc_pkg::OUT_IDX_W-1:0]     out_entry_index,
  output logic                               out_released,
  output logic [lskc_pkg::HANDLE_PORT_W-1:0] out_released_handle,
  output logic                               out_last_result
);

  localparam int HPW = lskc_pkg::HANDLE_PORT_W;
  localparam int OIW = lskc_pkg::OUT_IDX_W;
  localparam int SW  = lskc_pkg::STAMP_W;
  localparam int HW  = (HANDLE_BITS < HPW) ? HANDLE_BITS : HPW;
  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [lskc_pkg::KEY_W-1:0] key;
    logic [HW-1:0]              handle;
    logic [SW-1:0]              stamp;
  } entry_t;

  entry_t mem [ENTRIES];

  lskc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [SW-1:0]    clock_r, clock_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]    rd_idx_r;
  entry_t           rdata_r;
  logic             out_valid_r, out_valid_nxt;

  logic [lskc_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                       aok_r, aok_nxt;
  logic [HW-1:0]              ah_r, ah_nxt;
  logic [IW-1:0]              hit_idx_r, hit_idx_nxt;
  logic [HW-1:0]              hit_handle_r, hit_handle_nxt;
  logic [IW-1:0]              old_idx_r, old_idx_nxt;
  logic [SW-1:0]              old_stamp_r, old_stamp_nxt;
  logic [HW-1:0]              old_handle_r, old_handle_nxt;

  logic           o_hit_r, o_hit_nxt;
  logic           o_granted_r, o_granted_nxt;
  logic [HPW-1:0] o_handle_r, o_handle_nxt;
  logic [OIW-1:0] o_idx_r, o_idx_nxt;
  logic           o_rel_r, o_rel_nxt;
  logic [HPW-1:0] o_rel_handle_r, o_rel_handle_nxt;
  logic           o_last_r, o_last_nxt;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  logic          in_acc, out_free, full, alloc_ok;
  logic [CW-1:0] at_c;

  assign in_stall = (state_r != lskc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == CW'(ENTRIES));
  assign at_c     = full ? CW'(old_idx_r) : count_r;
  assign alloc_ok = aok_r && (ah_r != '0);

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    clock_nxt        = clock_r;
    issue_nxt        = issue_r;
    rd_vld_nxt       = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;
    key_nxt          = key_r;
    aok_nxt          = aok_r;
    ah_nxt           = ah_r;
    hit_idx_nxt      = hit_idx_r;
    hit_handle_nxt   = hit_handle_r;
    old_idx_nxt      = old_idx_r;
    old_stamp_nxt    = old_stamp_r;
    old_handle_nxt   = old_handle_r;
    o_hit_nxt        = o_hit_r;
    o_granted_nxt    = o_granted_r;
    o_handle_nxt     = o_handle_r;
    o_idx_nxt        = o_idx_r;
    o_rel_nxt        = o_rel_r;
    o_rel_handle_nxt = o_rel_handle_r;
    o_last_nxt       = o_last_r;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = rdata_r;
    mem_re           = 1'b0;
    mem_raddr        = '0;

    case (state_r)
      lskc_pkg::ST_IDLE: begin
        if (in_acc) begin
          key_nxt   = {in_key_group, in_key_n, in_key_k, in_key_m};
          aok_nxt   = in_alloc_ok;
          ah_nxt    = in_alloc_handle[HW-1:0];
          issue_nxt = '0;
          state_nxt = (in_command == lskc_pkg::CMD_CLEAR) ? lskc_pkg::ST_CLR_RD
                                                          : lskc_pkg::ST_SCAN;
        end
      end
      lskc_pkg::ST_SCAN: begin
        if (rd_vld_r && rdata_r.key == key_r) begin
          hit_idx_nxt    = rd_idx_r;
          hit_handle_nxt = rdata_r.handle;
          state_nxt      = lskc_pkg::ST_HIT;
        end else begin
          if (rd_vld_r && (rd_idx_r == '0 || rdata_r.stamp < old_stamp_r)) begin
            old_idx_nxt    = rd_idx_r;
            old_stamp_nxt  = rdata_r.stamp;
            old_handle_nxt = rdata_r.handle;
          end
          if (issue_r < count_r) begin
            mem_re     = 1'b1;
            mem_raddr  = issue_r[IW-1:0];
            issue_nxt  = issue_r + CW'(1);
            rd_vld_nxt = 1'b1;
          end else if (!rd_vld_r) begin
            state_nxt = lskc_pkg::ST_DECIDE;
          end
        end
      end
      lskc_pkg::ST_HIT: begin
        if (out_free) begin
          mem_we           = 1'b1;
          mem_waddr        = hit_idx_r;
          mem_wdata        = '{key: key_r, handle: hit_handle_r, stamp: clock_r + SW'(1)};
          clock_nxt        = clock_r + SW'(1);
          out_valid_nxt    = 1'b1;
          o_hit_nxt        = 1'b1;
          o_granted_nxt    = 1'b1;
          o_handle_nxt     = HPW'(hit_handle_r);
          o_idx_nxt        = OIW'(hit_idx_r);
          o_rel_nxt        = 1'b0;
          o_rel_handle_nxt = '0;
          o_last_nxt       = 1'b1;
          state_nxt        = lskc_pkg::ST_IDLE;
        end
      end
      lskc_pkg::ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          o_hit_nxt        = 1'b0;
          o_granted_nxt    = alloc_ok;
          o_handle_nxt     = alloc_ok ? HPW'(ah_r) : '0;
          o_idx_nxt        = OIW'(at_c);
          o_rel_nxt        = full;
          o_rel_handle_nxt = full ? HPW'(old_handle_r) : '0;
          o_last_nxt       = 1'b1;
          if (alloc_ok) begin
            mem_we    = 1'b1;
            mem_waddr = at_c[IW-1:0];
            mem_wdata = '{key: key_r, handle: ah_r, stamp: clock_r + SW'(1)};
            clock_nxt = clock_r + SW'(1);
            if (!full) begin
              count_nxt = count_r + CW'(1);
            end
            state_nxt = lskc_pkg::ST_IDLE;
          end else if (full) begin
            state_nxt = lskc_pkg::ST_MV_RD;
          end else begin
            state_nxt = lskc_pkg::ST_IDLE;
          end
        end
      end
      lskc_pkg::ST_MV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = IW'(count_r - CW'(1));
        state_nxt = lskc_pkg::ST_MV_WR;
      end
      lskc_pkg::ST_MV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = old_idx_r;
        mem_wdata = rdata_r;
        count_nxt = count_r - CW'(1);
        state_nxt = lskc_pkg::ST_IDLE;
      end
      lskc_pkg::ST_CLR_RD: begin
        if (issue_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = issue_r[IW-1:0];
          state_nxt = lskc_pkg::ST_CLR_EMIT;
        end else begin
          count_nxt = '0;
          state_nxt = lskc_pkg::ST_IDLE;
        end
      end
      lskc_pkg::ST_CLR_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          o_hit_nxt        = 1'b0;
          o_granted_nxt    = 1'b0;
          o_handle_nxt     = '0;
          o_idx_nxt        = OIW'(issue_r);
          o_rel_nxt        = 1'b1;
          o_rel_handle_nxt = HPW'(rdata_r.handle);
          o_last_nxt       = (issue_r + CW'(1) == count_r);
          issue_nxt        = issue_r + CW'(1);
          state_nxt        = lskc_pkg::ST_CLR_RD;
        end
      end
      default: begin
        state_nxt = lskc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lskc_pkg::ST_IDLE;
      count_r     <= '0;
      clock_r     <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clock_r     <= clock_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    aok_r          <= aok_nxt;
    ah_r           <= ah_nxt;
    hit_idx_r      <= hit_idx_nxt;
    hit_handle_r   <= hit_handle_nxt;
    old_idx_r      <= old_idx_nxt;
    old_stamp_r    <= old_stamp_nxt;
    old_handle_r   <= old_handle_nxt;
    o_hit_r        <= o_hit_nxt;
    o_granted_r    <= o_granted_nxt;
    o_handle_r     <= o_handle_nxt;
    o_idx_r        <= o_idx_nxt;
    o_rel_r        <= o_rel_nxt;
    o_rel_handle_r <= o_rel_handle_nxt;
    o_last_r       <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r  <= mem[mem_raddr];
      rd_idx_r <= mem_raddr;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = o_hit_r;
  assign out_granted         = o_granted_r;
  assign out_handle_out      = o_handle_r;
  assign out_entry_index     = o_idx_r;
  assign out_released        = o_rel_r;
  assign out_released_handle = o_rel_handle_r;
  assign out_last_result     = o_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count exceeds table size");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != lskc_pkg::ST_IDLE)
    else $error("accepted beat did not start work");

  a_hit_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_hit_r |-> o_granted_r && !o_rel_r)
    else $error("hit beat without a granted handle");

  a_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_granted_r |-> o_handle_r == '0)
    else $error("handle returned without a grant");

endmodule
